FILE: design/flrt_pkg.sv
//------------------------------------------------------------------------------
// flrt_pkg
// Shared types and constants of the free-list row table.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package flrt_pkg;

  localparam int STORE_WORDS_DEF = 1024;
  localparam int MAX_FIELDS_DEF  = 8;

  localparam int WORD_W  = 32;
  localparam int ROW_W   = 10;
  localparam int FIELD_W = 3;
  localparam int CNT_W   = 11;
  localparam int FPR_W   = 4;
  // row * fields + field stays below 1023 * 15 + 8
  localparam int LIN_W   = 14;

  localparam int ROW_LIMIT = 1024;
  localparam logic [WORD_W-1:0] NO_LINK = '1;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_ERASE  = 3'd1,
    KIND_READ   = 3'd2,
    KIND_WRITE  = 3'd3,
    KIND_PUSH   = 3'd4,
    KIND_POP    = 3'd5,
    KIND_CLEAR  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_QUOT,
    S_MEM,
    S_RESP
  } state_e;

  typedef struct packed {
    kind_e                     kind;
    logic [ROW_W-1:0]          row_index;
    logic [FIELD_W-1:0]        field_index;
    logic signed [WORD_W-1:0]  write_value;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]          given_row;
    logic signed [WORD_W-1:0]  read_value;
    logic [CNT_W-1:0]          row_count;
    status_e                   status;
  } rsp_t;

endpackage

`default_nettype wire

FILE: design/free_list_row_table.sv
//------------------------------------------------------------------------------
// free_list_row_table
// Row table in one word store with a linked free list of erased rows.
//------------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// command   in         start && !busy            cmd_i  (flrt_pkg::cmd_t)
// result    out        done_o, one-cycle strobe  rsp_o  (flrt_pkg::rsp_t)
// config    in         cfg_we_i                  cfg_wdata_i (fields_per_row)
//
// Transactions do not overlap: busy stays high through the quotient, memory and
// response states, done_o rises as busy falls, and the next command can be
// accepted in that same cycle. These states serve the address unit (index
// multiply, reciprocal quotient, remainder) and the registered read of the word
// store port. Reset clears row count and free list; the store itself is not
// cleared. Results cannot be stalled.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module free_list_row_table #(
  parameter int STORE_WORDS = flrt_pkg::STORE_WORDS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire flrt_pkg::cmd_t             cmd_i,
  output logic                            done_o,
  output flrt_pkg::rsp_t                  rsp_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [flrt_pkg::FPR_W-1:0] cfg_wdata_i
);

  localparam int MAX_FIELDS = flrt_pkg::MAX_FIELDS_DEF;
  localparam int ADDR_W = $clog2(STORE_WORDS);
  localparam int NEED_W = ((flrt_pkg::LIN_W > ADDR_W) ? flrt_pkg::LIN_W : ADDR_W) + 1;
  localparam int WORD_W = flrt_pkg::WORD_W;
  localparam int ROW_W  = flrt_pkg::ROW_W;
  localparam int CNT_W  = flrt_pkg::CNT_W;
  localparam int FPR_W  = flrt_pkg::FPR_W;

  flrt_pkg::state_e  state_q, state_d;
  flrt_pkg::cmd_t    cmd_q;
  flrt_pkg::rsp_t    rsp_q, rsp_d;
  logic              done_q, done_d;
  logic [FPR_W-1:0]  fpr_q;
  logic [CNT_W-1:0]  rows_q, rows_d;
  logic [ROW_W-1:0]  head_q, head_d;
  logic              head_vld_q, head_vld_d;

  logic              accept;
  logic [FPR_W-1:0]  eff;
  logic [ROW_W-1:0]  row_sel;
  logic [flrt_pkg::FIELD_W-1:0] field_sel;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;
  logic              row_ok, field_ok, full;
  logic [NEED_W-1:0] need_words;

  assign busy   = (state_q != flrt_pkg::S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (fpr_q == '0) begin
      eff = FPR_W'(1);
    end else if (int'(fpr_q) > MAX_FIELDS) begin
      eff = FPR_W'(MAX_FIELDS);
    end else begin
      eff = fpr_q;
    end
  end

  assign row_sel   = (cmd_i.kind == flrt_pkg::KIND_INSERT) ? head_q : cmd_i.row_index;
  assign field_sel = (cmd_i.kind == flrt_pkg::KIND_INSERT ||
                      cmd_i.kind == flrt_pkg::KIND_ERASE) ? '0 : cmd_i.field_index;

  flrt_addr_gen #(
    .STORE_WORDS (STORE_WORDS),
    .ADDR_W      (ADDR_W)
  ) u_addr_gen (
    .clk_i   (clk_i),
    .load_i  (accept),
    .row_i   (row_sel),
    .field_i (field_sel),
    .eff_i   (eff),
    .addr_o  (mem_addr)
  );

  assign row_ok     = {1'b0, cmd_q.row_index} < rows_q;
  assign field_ok   = {1'b0, cmd_q.field_index} < eff;
  assign need_words = NEED_W'(rows_q + CNT_W'(1)) * NEED_W'(eff);
  assign full       = (rows_q >= CNT_W'(flrt_pkg::ROW_LIMIT)) ||
                      (need_words > NEED_W'(STORE_WORDS));

  assign mem_we = (state_q == flrt_pkg::S_MEM) && row_ok &&
                  ((cmd_q.kind == flrt_pkg::KIND_ERASE) ||
                   (cmd_q.kind == flrt_pkg::KIND_WRITE && field_ok));
  assign mem_wdata = (cmd_q.kind == flrt_pkg::KIND_ERASE) ?
                     (head_vld_q ? WORD_W'(head_q) : flrt_pkg::NO_LINK) :
                     WORD_W'(cmd_q.write_value);

  flrt_word_ram #(
    .DEPTH  (STORE_WORDS),
    .ADDR_W (ADDR_W)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= flrt_pkg::S_IDLE;
      done_q     <= 1'b0;
      fpr_q      <= FPR_W'(1);
      rows_q     <= '0;
      head_q     <= '0;
      head_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      done_q     <= done_d;
      rows_q     <= rows_d;
      head_q     <= head_d;
      head_vld_q <= head_vld_d;
      if (cfg_we_i) begin
        fpr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    rsp_q <= rsp_d;
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      flrt_pkg::S_IDLE: begin
        if (accept) begin
          state_d = flrt_pkg::S_QUOT;
        end
      end
      flrt_pkg::S_QUOT: state_d = flrt_pkg::S_MEM;
      flrt_pkg::S_MEM:  state_d = flrt_pkg::S_RESP;
      flrt_pkg::S_RESP: begin
        state_d = flrt_pkg::S_IDLE;
        done_d  = 1'b1;
      end
      default: state_d = flrt_pkg::S_IDLE;
    endcase
  end

  // result and table state update, applied at the end of the response cycle
  always_comb begin
    rows_d     = rows_q;
    head_d     = head_q;
    head_vld_d = head_vld_q;
    rsp_d      = rsp_q;
    if (state_q == flrt_pkg::S_RESP) begin
      rsp_d.given_row  = '0;
      rsp_d.read_value = '0;
      rsp_d.status     = flrt_pkg::ST_OK;
      case (cmd_q.kind)
        flrt_pkg::KIND_INSERT, flrt_pkg::KIND_PUSH: begin
          if (cmd_q.kind == flrt_pkg::KIND_INSERT && head_vld_q) begin
            rsp_d.given_row = head_q;
            if (mem_rdata < WORD_W'(flrt_pkg::ROW_LIMIT)) begin
              head_d = ROW_W'(mem_rdata);
            end else begin
              head_d     = '0;
              head_vld_d = 1'b0;
            end
          end else if (full) begin
            rsp_d.status = flrt_pkg::ST_FULL;
          end else begin
            rsp_d.given_row = ROW_W'(rows_q);
            rows_d          = rows_q + CNT_W'(1);
          end
        end
        flrt_pkg::KIND_ERASE: begin
          if (!row_ok) begin
            rsp_d.status = flrt_pkg::ST_RANGE;
          end else begin
            head_d     = cmd_q.row_index;
            head_vld_d = 1'b1;
          end
        end
        flrt_pkg::KIND_READ: begin
          if (!(row_ok && field_ok)) begin
            rsp_d.status = flrt_pkg::ST_RANGE;
          end else begin
            rsp_d.read_value = mem_rdata;
          end
        end
        flrt_pkg::KIND_WRITE: begin
          if (!(row_ok && field_ok)) begin
            rsp_d.status = flrt_pkg::ST_RANGE;
          end
        end
        flrt_pkg::KIND_POP: begin
          if (rows_q == '0) begin
            rsp_d.status = flrt_pkg::ST_EMPTY;
          end else begin
            rows_d = rows_q - CNT_W'(1);
          end
        end
        flrt_pkg::KIND_CLEAR: begin
          rows_d     = '0;
          head_d     = '0;
          head_vld_d = 1'b0;
        end
        default: ;
      endcase
      rsp_d.row_count = rows_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

FILE: design/flrt_word_ram.sv
//------------------------------------------------------------------------------
// flrt_word_ram
// Single-port word store, one access per cycle, read-before-write, registered read data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flrt_word_ram #(
  parameter int DEPTH  = flrt_pkg::STORE_WORDS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [ADDR_W-1:0]          addr_i,
  input  wire logic [flrt_pkg::WORD_W-1:0] wdata_i,
  output logic      [flrt_pkg::WORD_W-1:0] rdata_o
);

  logic [flrt_pkg::WORD_W-1:0] mem [DEPTH];
  logic [flrt_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/flrt_addr_gen.sv
//------------------------------------------------------------------------------
// flrt_addr_gen
// Word address = (row * fields + field) mod STORE_WORDS.
// Linear index registered at load, quotient by reciprocal multiply registered
// next cycle, remainder with one correction step after that.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flrt_addr_gen #(
  parameter int STORE_WORDS = flrt_pkg::STORE_WORDS_DEF,
  parameter int ADDR_W      = $clog2(STORE_WORDS)
) (
  input  wire logic                         clk_i,
  input  wire logic                         load_i,
  input  wire logic [flrt_pkg::ROW_W-1:0]   row_i,
  input  wire logic [flrt_pkg::FIELD_W-1:0] field_i,
  input  wire logic [flrt_pkg::FPR_W-1:0]   eff_i,
  output logic      [ADDR_W-1:0]            addr_o
);

  localparam int LIN_W   = flrt_pkg::LIN_W;
  localparam int SHIFT   = LIN_W + ADDR_W;
  localparam int RECIP_W = LIN_W + 1;
  localparam int PROD_W  = LIN_W + RECIP_W;
  localparam int CMP_W   = ((LIN_W > ADDR_W) ? LIN_W : ADDR_W) + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << SHIFT) / 64'(STORE_WORDS));

  logic [LIN_W-1:0]  lin_q, lin_d;
  logic [LIN_W-1:0]  quot_q, quot_d;
  logic [PROD_W-1:0] prod;
  logic [CMP_W-1:0]  back, rem, rem_fix;

  assign lin_d = LIN_W'(row_i) * LIN_W'(eff_i) + LIN_W'(field_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lin_q <= lin_d;
    end
    quot_q <= quot_d;
  end

  // estimate never exceeds the true quotient and is at most one below it
  assign prod   = PROD_W'(lin_q) * PROD_W'(RECIP);
  assign quot_d = LIN_W'(prod >> SHIFT);

  assign back    = CMP_W'(quot_q) * CMP_W'(STORE_WORDS);
  assign rem     = CMP_W'(lin_q) - back;
  assign rem_fix = (rem >= CMP_W'(STORE_WORDS)) ? rem - CMP_W'(STORE_WORDS) : rem;
  assign addr_o  = ADDR_W'(rem_fix);

endmodule

`default_nettype wire

FILE: design/flrt_checker.sv
//------------------------------------------------------------------------------
// flrt_checker
// Port-level timing and result checks for free_list_row_table.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flrt_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done_o,
  input wire flrt_pkg::rsp_t rsp_o
);

  logic accept;
  assign accept = start && !busy;

  // every accepted transaction is answered by a done_o pulse
  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("missing result after accepted transaction");

  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result without a transaction");

  a_busy_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy ##1 busy ##1 busy)
    else $error("busy dropped during a transaction");

  a_fail_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != flrt_pkg::ST_OK |->
      rsp_o.given_row == '0 && rsp_o.read_value == '0)
    else $error("failed transaction returned data");

endmodule

bind free_list_row_table flrt_checker u_flrt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire
